// ===== rtl/rwst_pkg.sv =====
// Package for the running window statistic unit: codes, states and control structs.
`default_nettype none
package rwst_pkg;

  // Statistic selector codes
  typedef enum logic [1:0] {
    STAT_MEAN   = 2'd0,
    STAT_MEDIAN = 2'd1,
    STAT_MIN    = 2'd2,
    STAT_MAX    = 2'd3
  } stat_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_TYPE   = 2'd0,
    CFG_VMAX   = 2'd1,
    CFG_VMIN   = 2'd2,
    CFG_WINLEN = 2'd3
  } cfg_idx_e;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned CFG_IDX_W = 2;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DIV_INIT,
    ST_DIV,
    ST_MED_LOAD,
    ST_MED_CNT,
    ST_MED_CHECK,
    ST_DONE
  } state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic take;          // input word accepted
    logic scan_step;     // accumulate one entry
    logic div_load;      // start division
    logic div_step;      // one quotient bit
    logic med_load;      // fetch median candidate
    logic med_step;      // compare one entry to candidate
    logic med_next;      // move to next candidate
    logic stat_ext;      // store min/max result
    logic stat_div;      // store mean result
    logic stat_cand;     // store median result
    logic out_load;      // load output register
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    stat_e stype;
    logic  in_band;
    logic  scan_last;
    logic  div_last;
    logic  med_found;
  } sts_t;

endpackage
`default_nettype wire

// ===== rtl/running_window_statistic_unit.sv =====
// Top level of the running window statistic unit.
// Usage:
//  - Input channel in_valid_i/in_ready_o carries one 16-bit sample word.
//  - Output channel out_valid_o/out_ready_i carries statistic_o and accepted_o.
//  - cfg_we_i/cfg_idx_i/cfg_data_i write the type, band limits and window length.
//  - One sample is processed at a time; in_ready_o is high only when idle.
//  - Mean divides the sum, of width W = 16 + clog2(MAX_WINDOW+1), with a
//    restoring divider, one quotient bit per cycle; the median counts each
//    candidate against all entries.
//  - The store has one read port, so each scan reads the entries one at a time.
//  - A finished result waits in the output register while a new sample may be
//    taken; the next result is held internally until the receiver takes the
//    previous one.
//  - Reset clears the fill count, the stored statistic and config to defaults.
`default_nettype none
module running_window_statistic_unit #(
  parameter int unsigned MAX_WINDOW = 16
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [rwst_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [rwst_pkg::SAMPLE_W-1:0]  cfg_data_i,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic [rwst_pkg::SAMPLE_W-1:0]  sample_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic [rwst_pkg::SAMPLE_W-1:0]       statistic_o,
  output logic                                accepted_o
);

  rwst_pkg::cmd_t cmd;
  rwst_pkg::sts_t sts;

  rwst_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  rwst_dp #(.MAX_WINDOW(MAX_WINDOW)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .sample_i    (sample_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .statistic_o (statistic_o),
    .accepted_o  (accepted_o)
  );

endmodule
`default_nettype wire

// ===== rtl/rwst_ctrl.sv =====
// Controller state machine for the running window statistic unit.
`default_nettype none
module rwst_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  input  wire rwst_pkg::sts_t sts_i,
  output rwst_pkg::cmd_t     cmd_o
);

  rwst_pkg::state_e state_q, state_d;
  logic out_valid_q, out_valid_d;

  // State and output valid registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rwst_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == rwst_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;

  // Next state and commands
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      rwst_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          if (!sts_i.in_band) begin
            state_d = rwst_pkg::ST_DONE;
          end else if (sts_i.stype == rwst_pkg::STAT_MEDIAN) begin
            state_d = rwst_pkg::ST_MED_LOAD;
          end else begin
            state_d = rwst_pkg::ST_SCAN;
          end
        end
      end
      rwst_pkg::ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_last) begin
          if (sts_i.stype == rwst_pkg::STAT_MEAN) begin
            state_d = rwst_pkg::ST_DIV_INIT;
          end else begin
            state_d = rwst_pkg::ST_DONE;
          end
        end
      end
      rwst_pkg::ST_DIV_INIT: begin
        cmd_o.div_load = 1'b1;
        state_d = rwst_pkg::ST_DIV;
      end
      rwst_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = rwst_pkg::ST_DONE;
        end
      end
      rwst_pkg::ST_MED_LOAD: begin
        cmd_o.med_load = 1'b1;
        state_d = rwst_pkg::ST_MED_CNT;
      end
      rwst_pkg::ST_MED_CNT: begin
        cmd_o.med_step = 1'b1;
        if (sts_i.scan_last) begin
          state_d = rwst_pkg::ST_MED_CHECK;
        end
      end
      rwst_pkg::ST_MED_CHECK: begin
        if (sts_i.med_found) begin
          cmd_o.stat_cand = 1'b1;
          state_d = rwst_pkg::ST_DONE;
        end else begin
          cmd_o.med_next = 1'b1;
          state_d = rwst_pkg::ST_MED_LOAD;
        end
      end
      rwst_pkg::ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d = 1'b1;
          state_d = rwst_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = rwst_pkg::ST_IDLE;
      end
    endcase
    // min/max result is final once the scan ends
    if (state_q == rwst_pkg::ST_SCAN && sts_i.scan_last &&
        sts_i.stype != rwst_pkg::STAT_MEAN) begin
      cmd_o.stat_ext = 1'b1;
    end
    if (state_q == rwst_pkg::ST_DIV && sts_i.div_last) begin
      cmd_o.stat_div = 1'b1;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/rwst_dp.sv =====
// Datapath: config registers, sample window, scan, divider, median counters, output.
`default_nettype none
module rwst_dp #(
  parameter int unsigned MAX_WINDOW = 16
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [rwst_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [rwst_pkg::SAMPLE_W-1:0]     cfg_data_i,
  input  wire logic [rwst_pkg::SAMPLE_W-1:0]     sample_i,
  input  wire rwst_pkg::cmd_t                    cmd_i,
  output rwst_pkg::sts_t                         sts_o,
  output logic [rwst_pkg::SAMPLE_W-1:0]          statistic_o,
  output logic                                   accepted_o
);

  localparam int unsigned SW    = rwst_pkg::SAMPLE_W;
  localparam int unsigned CNT_W = $clog2(MAX_WINDOW + 1);
  localparam int unsigned IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int unsigned SUM_W = SW + CNT_W;
  localparam int unsigned DC_W  = $clog2(SUM_W + 1);

  // Configuration registers
  rwst_pkg::stat_e stype_q;
  logic [SW-1:0]   vmax_q, vmin_q;
  logic [4:0]      wlen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stype_q <= rwst_pkg::STAT_MEAN;
      vmax_q  <= {SW{1'b1}};
      vmin_q  <= '0;
      wlen_q  <= 5'd16;
    end else if (cfg_we_i) begin
      unique case (rwst_pkg::cfg_idx_e'(cfg_idx_i))
        rwst_pkg::CFG_TYPE:   stype_q <= rwst_pkg::stat_e'(cfg_data_i[1:0]);
        rwst_pkg::CFG_VMAX:   vmax_q  <= cfg_data_i;
        rwst_pkg::CFG_VMIN:   vmin_q  <= cfg_data_i;
        rwst_pkg::CFG_WINLEN: wlen_q  <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  // Effective window length: zero counts as one, clipped to the store depth
  logic [CNT_W-1:0] len;
  always_comb begin
    if (wlen_q == 5'd0) begin
      len = CNT_W'(1);
    end else if (int'(wlen_q) > int'(MAX_WINDOW)) begin
      len = CNT_W'(MAX_WINDOW);
    end else begin
      len = CNT_W'(wlen_q);
    end
  end

  logic in_band;
  assign in_band = (sample_i >= vmin_q) && (sample_i <= vmax_q);
  logic push;
  assign push = cmd_i.take && in_band;

  // Fill count
  logic [CNT_W-1:0] fill_q;
  logic [CNT_W:0]   fill_inc;
  assign fill_inc = {1'b0, fill_q} + (CNT_W+1)'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else if (push) begin
      if (fill_inc > {1'b0, len}) begin
        fill_q <= len;
      end else begin
        fill_q <= fill_inc[CNT_W-1:0];
      end
    end
  end

  // Window store, newest at entry 0
  logic [SW-1:0] store_q [MAX_WINDOW];
  always_ff @(posedge clk_i) begin
    if (push) begin
      store_q[0] <= sample_i;
      for (int k = 1; k < int'(MAX_WINDOW); k++) begin
        if (CNT_W'(k) <= fill_q && CNT_W'(k) < len) begin
          store_q[k] <= store_q[k-1];
        end
      end
    end
  end

  // Scan and candidate indexes, one store read per cycle
  logic [CNT_W-1:0] j_q, i_q;
  logic [IDX_W-1:0] rd_idx;
  logic [SW-1:0]    rd;
  assign rd_idx = cmd_i.med_load ? i_q[IDX_W-1:0] : j_q[IDX_W-1:0];
  assign rd     = store_q[rd_idx];

  logic [CNT_W-1:0] n_last;
  assign n_last = fill_q - CNT_W'(1);
  logic [CNT_W-1:0] kmid;
  assign kmid = n_last >> 1;

  logic [SUM_W-1:0] sum_q;
  logic [SW-1:0]    ext_q, cand_q, stat_q;
  logic [CNT_W-1:0] lt_q, le_q;

  // Division registers (quotient shifts in over the dividend)
  logic [SUM_W-1:0] quo_q;
  logic [CNT_W-1:0] rem_q;
  logic [DC_W-1:0]  dcnt_q;
  logic [CNT_W:0]   trial;
  logic             tfit;
  assign trial = {rem_q, quo_q[SUM_W-1]};
  assign tfit  = trial >= {1'b0, fill_q};

  logic better;
  always_comb begin
    if (stype_q == rwst_pkg::STAT_MIN) begin
      better = rd < ext_q;
    end else begin
      better = rd > ext_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      j_q    <= '0;
      i_q    <= '0;
      dcnt_q <= '0;
      stat_q <= '0;
    end else begin
      if (cmd_i.take) begin
        j_q <= '0;
        i_q <= '0;
      end
      if (cmd_i.scan_step || cmd_i.med_step) begin
        j_q <= j_q + CNT_W'(1);
      end
      if (cmd_i.med_load) begin
        j_q <= '0;
      end
      if (cmd_i.med_next) begin
        i_q <= i_q + CNT_W'(1);
      end
      if (cmd_i.div_load) begin
        dcnt_q <= '0;
      end else if (cmd_i.div_step) begin
        dcnt_q <= dcnt_q + DC_W'(1);
      end
      // first entry of the scan always counts, even when it is the only one
      if (cmd_i.stat_ext) begin
        stat_q <= (j_q == '0 || better) ? rd : ext_q;
      end
      if (cmd_i.stat_div) begin
        stat_q <= quo_q[SW-2:0] == '0 ? {quo_q[SW-2:0], tfit} : {quo_q[SW-2:0], tfit};
      end
      if (cmd_i.stat_cand) begin
        stat_q <= cand_q;
      end
    end
  end

  // Datapath payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      sum_q <= '0;
    end
    if (cmd_i.scan_step) begin
      sum_q <= sum_q + SUM_W'(rd);
      if (j_q == '0 || better) begin
        ext_q <= rd;
      end
    end
    if (cmd_i.div_load) begin
      quo_q <= sum_q + SUM_W'(fill_q >> 1);
      rem_q <= '0;
    end
    if (cmd_i.div_step) begin
      quo_q <= {quo_q[SUM_W-2:0], tfit};
      rem_q <= tfit ? CNT_W'(trial - {1'b0, fill_q}) : trial[CNT_W-1:0];
    end
    if (cmd_i.med_load) begin
      cand_q <= rd;
      lt_q   <= '0;
      le_q   <= '0;
    end
    if (cmd_i.med_step) begin
      lt_q <= lt_q + CNT_W'(rd < cand_q);
      le_q <= le_q + CNT_W'(rd <= cand_q);
    end
  end

  // Output register and accepted flag
  logic acc_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      acc_q <= in_band;
    end
    if (cmd_i.out_load) begin
      statistic_o <= stat_q;
      accepted_o  <= acc_q;
    end
  end

  assign sts_o.stype     = stype_q;
  assign sts_o.in_band   = in_band;
  assign sts_o.scan_last = (j_q == n_last);
  assign sts_o.div_last  = (dcnt_q == DC_W'(SUM_W - 1));
  assign sts_o.med_found = (lt_q <= kmid) && (kmid < le_q);

endmodule
`default_nettype wire

// ===== rtl/rwst_checker.sv =====
// Port-level checker for the running window statistic unit, with its bind.
`default_nettype none
module rwst_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          in_valid_i,
  input wire logic                          in_ready_o,
  input wire logic                          out_valid_o,
  input wire logic                          out_ready_i,
  input wire logic [rwst_pkg::SAMPLE_W-1:0] statistic_o,
  input wire logic                          accepted_o
);

  // A stalled result word stays valid
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  // A stalled result word keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(statistic_o) && $stable(accepted_o))
    else $error("result payload changed while stalled");

  // One word at a time: ready drops after a sample is taken
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second sample taken while busy");

  // A new result only appears after a busy cycle
  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared without processing");

endmodule

bind running_window_statistic_unit rwst_checker u_rwst_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .statistic_o (statistic_o),
  .accepted_o  (accepted_o)
);
`default_nettype wire

// ===== dv/tb_running_window_statistic_unit.sv =====
// Self-checking testbench for the running window statistic unit.
`timescale 1ns / 1ps
`default_nettype none
module tb_running_window_statistic_unit;

  localparam int unsigned WIN = 16;
  localparam int unsigned CYCLE_LIMIT = 2000000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [15:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [15:0] sample_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [15:0] statistic_o;
  logic        accepted_o;

  running_window_statistic_unit #(.MAX_WINDOW(WIN)) u_top (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .sample_i,
    .out_valid_o, .out_ready_i, .statistic_o, .accepted_o
  );

  // Clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state and configuration
  rwst_pkg::stat_e mdl_type;
  logic [15:0] mdl_vmax, mdl_vmin;
  logic [4:0]  mdl_winlen;
  logic [15:0] win_store [WIN];
  int unsigned fill_cnt;
  logic [15:0] last_stat;

  typedef struct packed {
    logic [15:0] statistic;
    logic        accepted;
  } result_t;

  result_t pending_results[$];
  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt = 0;
  logic        long_stall = 1'b0;

  // Reports one mismatch
  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("MISMATCH %s: got %0d expected %0d at cycle %0d", what, got, want, cycle_cnt);
    mismatch_cnt++;
  endtask

  // Updates the window with one in-band sample and returns the result word
  function automatic result_t predict_statistic(input logic [15:0] s);
    result_t     r;
    int unsigned len, n, i, j;
    logic [31:0] sum;
    logic [15:0] srt [WIN];
    logic [15:0] v;
    len = (mdl_winlen == 0) ? 1 : ((mdl_winlen > WIN) ? WIN : 32'(mdl_winlen));
    if (s < mdl_vmin || s > mdl_vmax) begin
      r.statistic = last_stat;
      r.accepted  = 1'b0;
      return r;
    end
    for (i = fill_cnt; i > 0; i--)
      if (i < len) win_store[i] = win_store[i-1];
    win_store[0] = s;
    n = (fill_cnt + 1 > len) ? len : fill_cnt + 1;
    fill_cnt = n;
    case (mdl_type)
      rwst_pkg::STAT_MEAN: begin
        sum = '0;
        for (i = 0; i < n; i++) sum += 32'(win_store[i]);
        last_stat = 16'((sum + n / 2) / n);
      end
      rwst_pkg::STAT_MEDIAN: begin
        for (i = 0; i < n; i++) begin
          v = win_store[i];
          j = i;
          while (j > 0 && srt[j-1] > v) begin
            srt[j] = srt[j-1];
            j--;
          end
          srt[j] = v;
        end
        last_stat = srt[(n - 1) / 2];
      end
      default: begin
        last_stat = win_store[0];
        for (i = 1; i < n; i++)
          if (mdl_type == rwst_pkg::STAT_MAX ? win_store[i] > last_stat
                                             : win_store[i] < last_stat)
            last_stat = win_store[i];
      end
    endcase
    r.statistic = last_stat;
    r.accepted  = 1'b1;
    return r;
  endfunction

  // Register write, only while idle; the enable drops again before the task returns
  task automatic write_reg(input rwst_pkg::cfg_idx_e idx, input logic [15:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    @(posedge clk_i);
    case (idx)
      rwst_pkg::CFG_TYPE:   mdl_type   = rwst_pkg::stat_e'(val[1:0]);
      rwst_pkg::CFG_VMAX:   mdl_vmax   = val;
      rwst_pkg::CFG_VMIN:   mdl_vmin   = val;
      default:              mdl_winlen = val[4:0];
    endcase
  endtask

  task automatic configure(input rwst_pkg::stat_e t, input logic [15:0] lo,
                           input logic [15:0] hi, input logic [4:0] wl);
    write_reg(rwst_pkg::CFG_TYPE, 16'(t));
    write_reg(rwst_pkg::CFG_VMAX, hi);
    write_reg(rwst_pkg::CFG_VMIN, lo);
    write_reg(rwst_pkg::CFG_WINLEN, 16'(wl));
  endtask

  // Offers one word and waits for its acceptance
  task automatic send_word(input logic [15:0] s);
    in_valid_i <= 1'b1;
    sample_i   <= s;
    do @(posedge clk_i); while (!in_ready_o);
    pending_results.push_back(predict_statistic(s));
  endtask

  task automatic drop_valid_gap();
    int unsigned g;
    g = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
    if (g != 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(0, 5))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'($urandom_range(0, 15));
      default: return 16'($urandom);
    endcase
  endfunction

  // Directed rows: sample and, where obvious, the expected word
  typedef struct {
    logic [15:0] s;
    logic        known;
    result_t     want;
  } row_t;

  row_t dir_rows[$];

  // Sender
  initial begin
    int unsigned k, b, phase;
    mdl_type = rwst_pkg::STAT_MEAN; mdl_vmax = 16'hFFFF; mdl_vmin = '0; mdl_winlen = 5'd16;
    fill_cnt = 0; last_stat = '0;
    for (k = 0; k < WIN; k++) win_store[k] = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: extremes under the reset settings, then each mode
    dir_rows.push_back('{16'hFFFF, 1'b1, '{16'hFFFF, 1'b1}});
    dir_rows.push_back('{16'h0000, 1'b1, '{16'h8000, 1'b1}});
    dir_rows.push_back('{16'h0001, 1'b0, '0});
    dir_rows.push_back('{16'hFFFE, 1'b0, '0});
    foreach (dir_rows[i]) begin
      send_word(dir_rows[i].s);
      if (dir_rows[i].known && pending_results[$] != dir_rows[i].want)
        report_mismatch("directed row", 32'(pending_results[$]), 32'(dir_rows[i].want));
    end
    wait_drained();
    // Narrow band, window of one for the mean and of three otherwise, each statistic
    for (phase = 0; phase < 4; phase++) begin
      configure(rwst_pkg::stat_e'(phase), 16'd100, 16'd200, (phase == 0) ? 5'd0 : 5'd3);
      send_word(16'd99); send_word(16'd100); send_word(16'd201);
      send_word(16'd200); send_word(16'd150); send_word(16'd120);
      wait_drained();
    end
    // Empty band rejects all, then window above the limit and shortening
    configure(rwst_pkg::STAT_MAX, 16'd10, 16'd5, 5'd31);
    send_word(16'd7); send_word(16'd0);
    wait_drained();
    configure(rwst_pkg::STAT_MEDIAN, 16'd0, 16'hFFFF, 5'd31);
    for (k = 0; k < 5; k++) send_word(rand_sample());
    wait_drained();
    write_reg(rwst_pkg::CFG_WINLEN, 16'd2);
    send_word(16'd9);
    wait_drained();

    // Random part in phases of different settings
    for (phase = 0; phase < 12; phase++) begin
      case (phase % 4)
        0: configure(rwst_pkg::stat_e'($urandom_range(0, 3)), 16'd0, 16'hFFFF, 5'd16);
        1: configure(rwst_pkg::stat_e'($urandom_range(0, 3)), 16'd0, 16'hFFFF,
                     5'($urandom_range(1, 4)));
        2: configure(rwst_pkg::stat_e'($urandom_range(0, 3)), 16'($urandom_range(0, 30000)),
                     16'($urandom_range(30000, 65535)), 5'($urandom_range(0, 31)));
        default: configure(rwst_pkg::stat_e'($urandom_range(0, 3)), 16'($urandom),
                           16'($urandom), 5'($urandom_range(1, 16)));
      endcase
      if (phase == 5) long_stall <= 1'b1;
      k = 0;
      while (k < 135) begin
        b = $urandom_range(1, 20);
        if (b > 135 - k) b = 135 - k;
        repeat (b) begin
          send_word(rand_sample());
          k++;
        end
        drop_valid_gap();
      end
      wait_drained();
    end

    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (mismatch_cnt == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  // Receiver: own stall pattern, with one long hold-off
  initial begin
    int unsigned hold;
    forever begin
      @(posedge clk_i);
      if (long_stall) begin
        out_ready_i <= 1'b0;
        long_stall  <= 1'b0;
        for (hold = 0; hold < 400; hold++) @(posedge clk_i);
      end
      out_ready_i <= ($urandom_range(0, 9) < 6) || (cycle_cnt % 3000 < 500);
    end
  end

  // Output checker
  always @(posedge clk_i) begin
    result_t want;
    cycle_cnt <= cycle_cnt + 1;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected word", 32'(statistic_o), 0);
      end else begin
        want = pending_results.pop_front();
        if (statistic_o !== want.statistic)
          report_mismatch("statistic", 32'(statistic_o), 32'(want.statistic));
        if (accepted_o !== want.accepted)
          report_mismatch("accepted", 32'(accepted_o), 32'(want.accepted));
      end
    end
  end

  // Timeout
  always @(posedge clk_i) begin
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

endmodule
`default_nettype wire

// ===== filelist.f =====
rtl/rwst_pkg.sv
rtl/rwst_ctrl.sv
rtl/rwst_dp.sv
rtl/running_window_statistic_unit.sv
rtl/rwst_checker.sv
dv/tb_running_window_statistic_unit.sv
